### hdl/dlef_pkg.sv
package dlef_pkg;

    // Frame character constants
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_X = 8'h78;

    // Payload index saturates one past the longest frame
    localparam int MAX_LEN = 4096;
    localparam int IDX_W   = 13;
    localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(MAX_LEN + 1);

    // Configuration register indexes
    localparam logic CFG_STUFF_POSITION = 1'b0;
    localparam logic CFG_STUFF_CHAR     = 1'b1;

    // Work handed from front to back: what one input word turns into
    typedef struct packed {
        logic            open;    // emit opening delimiter first
        logic            fin;     // closes the frame
        logic [1:0]      cnt;     // payload characters to emit (0..3)
        logic            esc;     // first payload character gets a dle escape
        logic [2:0][7:0] chars;   // payload characters, slot 0 first
    } dlef_cmd_t;

endpackage

### hdl/dlef_front.sv
module dlef_front
    import dlef_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic [7:0] data_char,
    input  logic      is_final,
    output logic      push,
    output dlef_cmd_t push_cmd
);

    logic [1:0][7:0] la_reg, la_next;
    logic [1:0]      pend_reg, pend_next;
    logic            in_frame_reg, in_frame_next;
    logic [2:0][7:0] q;
    logic [1:0]      cnt;
    logic            q_dle;

    // Assemble the lookahead window with the new character
    always_comb
    begin
        q[0]  = (pend_reg != 2'd0) ? la_reg[0] : data_char;
        q[1]  = (pend_reg == 2'd2) ? la_reg[1] : data_char;
        q[2]  = data_char;
        cnt   = pend_reg + 2'd1;
        q_dle = (q[0] == CH_D) && (q[1] == CH_L) && (q[2] == CH_E);
    end

    // Classify the word into a command for the back end
    always_comb
    begin
        la_next       = la_reg;
        pend_next     = pend_reg;
        in_frame_next = in_frame_reg;
        push          = 1'b0;
        push_cmd.open  = !in_frame_reg;
        push_cmd.fin   = is_final;
        push_cmd.chars = q;
        push_cmd.cnt   = cnt;
        push_cmd.esc   = (cnt == 2'd3) && q_dle;
        if (in_fire)
        begin
            in_frame_next = !is_final;
            if (is_final)
            begin
                push      = 1'b1;
                pend_next = 2'd0;
                la_next   = '0;
            end
            else if (cnt == 2'd3)
            begin
                // Oldest character leaves, window slides by one
                push         = 1'b1;
                push_cmd.cnt = 2'd1;
                la_next[0]   = q[1];
                la_next[1]   = q[2];
                pend_next    = 2'd2;
            end
            else
            begin
                // Only fill the lookahead; an opening delimiter may still go out
                push             = !in_frame_reg;
                push_cmd.cnt     = 2'd0;
                la_next[pend_reg[0]] = data_char;
                pend_next        = cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_reg       <= '0;
            pend_reg     <= 2'd0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            la_reg       <= la_next;
            pend_reg     <= pend_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

### hdl/dlef_queue.sv
module dlef_queue
    import dlef_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  dlef_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output dlef_cmd_t head_cmd
);

    // Two-entry command queue
    dlef_cmd_t  mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### hdl/dlef_back.sv
module dlef_back
    import dlef_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] stuff_position,
    input  logic [7:0]       stuff_char,
    input  logic             head_valid,
    input  dlef_cmd_t        head_cmd,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_char,
    output logic             run_last,
    output logic             frame_end,
    output logic             position_error
);

    // Emission phases
    localparam logic [2:0] PH_OPEN  = 3'd0;
    localparam logic [2:0] PH_INS   = 3'd1;
    localparam logic [2:0] PH_ESC   = 3'd2;
    localparam logic [2:0] PH_CHR   = 3'd3;
    localparam logic [2:0] PH_CLOSE = 3'd4;

    dlef_cmd_t        cmd_reg;
    logic             busy_reg;
    logic [2:0]       phase_reg;
    logic [2:0]       step_reg;
    logic [1:0]       k_reg;
    logic [IDX_W-1:0] idx_reg, idx_next, idx_inc;
    logic             ins_reg, ins_next;

    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             run_last_reg, frame_end_reg, pos_err_reg;

    logic             fire, phase_end;
    logic [2:0]       last_step;
    logic [7:0]       cur_char;
    logic             cont_done;
    logic [2:0]       cont_phase;
    logic [1:0]       cont_k;
    logic [3:0]       start_dec;

    // What a payload slot starts with: {done, phase}
    function automatic logic [3:0] slot_start(
        input dlef_cmd_t        c,
        input logic [1:0]       k,
        input logic [IDX_W-1:0] idx,
        input logic             ins,
        input logic [IDX_W-1:0] pos
    );
        logic hit;
        logic [3:0] r;
        hit = !ins && ({1'b0, pos} == ({1'b0, idx} + (IDX_W+1)'(1)));
        if (k < c.cnt)
        begin
            if (hit)
                r = {1'b0, PH_INS};
            else if ((k == 2'd0) && c.esc)
                r = {1'b0, PH_ESC};
            else
                r = {1'b0, PH_CHR};
        end
        else if (c.fin)
        begin
            r = hit ? {1'b0, PH_INS} : {1'b0, PH_CLOSE};
        end
        else
        begin
            r = {1'b1, PH_CLOSE};
        end
        return r;
    endfunction

    // Phase length and current character
    always_comb
    begin
        last_step = 3'd0;
        cur_char  = CH_D;
        unique case (phase_reg)
            PH_OPEN:
            begin
                last_step = 3'd5;
                case (step_reg)
                    3'd0:    cur_char = CH_D;
                    3'd1:    cur_char = CH_L;
                    3'd2:    cur_char = CH_E;
                    3'd3:    cur_char = CH_S;
                    3'd4:    cur_char = CH_T;
                    default: cur_char = CH_X;
                endcase
            end
            PH_INS:
            begin
                last_step = 3'd6;
                case (step_reg)
                    3'd0, 3'd4: cur_char = CH_D;
                    3'd1, 3'd5: cur_char = CH_L;
                    3'd3:       cur_char = stuff_char;
                    default:    cur_char = CH_E;
                endcase
            end
            PH_ESC:
            begin
                last_step = 3'd2;
                case (step_reg)
                    3'd0:    cur_char = CH_D;
                    3'd1:    cur_char = CH_L;
                    default: cur_char = CH_E;
                endcase
            end
            PH_CHR:
            begin
                last_step = 3'd0;
                cur_char  = cmd_reg.chars[k_reg];
            end
            PH_CLOSE:
            begin
                last_step = 3'd5;
                case (step_reg)
                    3'd0:       cur_char = CH_D;
                    3'd1:       cur_char = CH_L;
                    3'd2, 3'd3: cur_char = CH_E;
                    3'd4:       cur_char = CH_T;
                    default:    cur_char = CH_X;
                endcase
            end
            default:
            begin
                last_step = 3'd0;
                cur_char  = CH_D;
            end
        endcase
    end

    assign fire      = busy_reg && (!out_valid_reg || out_ready);
    assign phase_end = fire && (step_reg == last_step);
    assign idx_inc   = (idx_reg < IDX_SAT) ? idx_reg + IDX_W'(1) : idx_reg;

    // Index and insertion flag after this cycle's character
    always_comb
    begin
        idx_next = idx_reg;
        ins_next = ins_reg;
        if (phase_end)
        begin
            case (phase_reg) inside
                PH_OPEN, PH_CLOSE:
                begin
                    idx_next = '0;
                    ins_next = 1'b0;
                end
                PH_INS:  ins_next = 1'b1;
                PH_CHR:  idx_next = idx_inc;
                default: ins_next = ins_reg;
            endcase
        end
    end

    // Next phase once the current one ends
    always_comb
    begin
        logic [3:0] d;
        d          = 4'd0;
        cont_done  = 1'b0;
        cont_phase = phase_reg;
        cont_k     = k_reg;
        unique case (phase_reg)
            PH_OPEN:
            begin
                cont_k = 2'd0;
                d      = slot_start(cmd_reg, 2'd0, idx_next, ins_next, stuff_position);
            end
            PH_INS:
            begin
                d = slot_start(cmd_reg, k_reg, idx_next, ins_next, stuff_position);
            end
            PH_ESC:
            begin
                d = {1'b0, PH_CHR};
            end
            PH_CHR:
            begin
                cont_k = k_reg + 2'd1;
                d      = slot_start(cmd_reg, cont_k, idx_next, ins_next, stuff_position);
            end
            PH_CLOSE:
            begin
                d = {1'b1, PH_CLOSE};
            end
            default:
            begin
                d = {1'b1, PH_CLOSE};
            end
        endcase
        cont_done  = d[3];
        cont_phase = d[2:0];
    end

    assign start_dec = slot_start(head_cmd, 2'd0, idx_next, ins_next, stuff_position);
    assign pop = head_valid && (!busy_reg || (phase_end && cont_done));

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_OPEN;
            step_reg  <= 3'd0;
            k_reg     <= 2'd0;
            idx_reg   <= '0;
            ins_reg   <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ins_reg <= ins_next;
            if (pop)
            begin
                busy_reg  <= 1'b1;
                step_reg  <= 3'd0;
                k_reg     <= 2'd0;
                phase_reg <= head_cmd.open ? PH_OPEN : start_dec[2:0];
            end
            else if (phase_end && cont_done)
            begin
                busy_reg <= 1'b0;
            end
            else if (phase_end)
            begin
                phase_reg <= cont_phase;
                k_reg     <= cont_k;
                step_reg  <= 3'd0;
            end
            else if (fire)
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head_cmd;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_char_reg  <= cur_char;
            run_last_reg  <= phase_end && cont_done;
            frame_end_reg <= (phase_reg == PH_CLOSE) && phase_end;
            pos_err_reg   <= (phase_reg == PH_CLOSE) && phase_end && !ins_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_char       = out_char_reg;
    assign run_last       = run_last_reg;
    assign frame_end      = frame_end_reg;
    assign position_error = pos_err_reg;

endmodule

### hdl/dle_character_stuffing_framer_core.sv
// DLE-STX / DLE-ETX character-stuffing framer.
// s_axis: one payload character per word in tdata, tlast marks the final one
// of a frame. m_axis: one character of the stuffed frame per word; tlast marks
// the last character caused by an input word, tuser flags the closing 'x'
// and a stuff position that never matched within the frame.
// cfg channel: index 0 writes the stuff position, index 1 the stuff
// character; always ready, write only while the block is idle.
// Input words are classified by a front end (two-character lookahead for the
// escape test) into commands that a back end sequencer expands through a
// two-entry command queue, one output character per cycle unless stalled.
// When the back end is idle, the first character of a word passes the command
// queue, the back end's command register and the output register. Throughput:
// one output character per cycle while the receiver accepts; input is taken
// every cycle while the queue has room.
// When the receiver stalls, the output register holds and the queue fills,
// then s_axis_tready drops. Reset clears the lookahead, the open-frame flag,
// the queue and the output; configuration returns to position 1, char 0.
module dle_character_stuffing_framer_core
    import dlef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_char
    input  logic        s_axis_tlast,   // is_final
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast,   // run_last
    output logic [1:0]  m_axis_tuser    // [0] frame_end, [1] position_error
);

    logic [IDX_W-1:0] stuff_position_reg;
    logic [7:0]       stuff_char_reg;
    logic             in_fire, push, full, pop, head_valid;
    dlef_cmd_t        push_cmd, head_cmd;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuff_position_reg <= IDX_W'(1);
            stuff_char_reg     <= 8'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STUFF_POSITION: stuff_position_reg <= cfg_data;
                CFG_STUFF_CHAR:     stuff_char_reg     <= cfg_data[7:0];
                default:            stuff_char_reg     <= stuff_char_reg;
            endcase
        end
    end

    assign s_axis_tready = !full;
    assign in_fire       = s_axis_tvalid && !full;

    dlef_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_char (s_axis_tdata),
        .is_final  (s_axis_tlast),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    dlef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    dlef_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .stuff_position (stuff_position_reg),
        .stuff_char     (stuff_char_reg),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_char       (m_axis_tdata),
        .run_last       (m_axis_tlast),
        .frame_end      (m_axis_tuser[0]),
        .position_error (m_axis_tuser[1])
    );

endmodule
